// File: hdl/end_marker_stream_deframer_assert.svh
// Assertion macros shared by the end marker stream deframer modules.
`ifndef END_MARKER_STREAM_DEFRAMER_ASSERT_SVH
`define END_MARKER_STREAM_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define EMD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define EMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define EMD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define EMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/emd_pkg.sv
// Types and constants of the end marker stream deframer.
`timescale 1ns / 1ps
package emd_pkg;

  localparam int MAX_MARKER_BYTES = 8;
  localparam int BUFFER_BYTES     = 4096;
  localparam int WIN_IDX_W        = $clog2(MAX_MARKER_BYTES);
  localparam int HELD_W           = 4;
  localparam int LEN_W            = 16;
  localparam int MARKER_W         = 64;
  localparam int MLEN_W           = 4;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

  localparam logic [MARKER_W-1:0] MARKER_RESET   = 64'd10;
  localparam logic [MLEN_W-1:0]   MLEN_RESET     = 4'd1;
  localparam logic [LEN_W-1:0]    MAX_LEN_RESET  = LEN_W'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    KIND_BYTE          = 3'd0,
    KIND_END           = 3'd1,
    KIND_EOF_NO_MARKER = 3'd2,
    KIND_OVERFLOW      = 3'd3,
    KIND_EOS           = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        out_byte;
    logic [LEN_W-1:0]  msg_len;
  } result_t;

endpackage

// File: hdl/emd_out_buf.sv
// Output register with skid stage for deframer results.
`timescale 1ns / 1ps
`include "end_marker_stream_deframer_assert.svh"
module emd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  emd_pkg::result_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output emd_pkg::result_t pop_data,
  input  logic             pop_ready
);
  import emd_pkg::*;

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    pop;

  assign push_ready = !skid_v_r;
  assign pop_valid  = out_v_r;
  assign pop_data   = out_d_r;
  assign pop        = out_v_r && pop_ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!out_v_r || pop) begin
      out_v_nxt = push_valid;
      if (push_valid) begin
        out_d_nxt = push_data;
      end
    end else if (push_valid) begin
      skid_d_nxt = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  `EMD_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `EMD_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
                   out_v_r && !pop_ready && push_valid && push_ready, skid_v_r)
  `EMD_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_v_r && pop_ready, !skid_v_r)

endmodule

// File: hdl/end_marker_stream_deframer.sv
// Top level of the end marker stream deframer.
// Usage: bytes enter on the in_ channel, one word per byte (in_tuser low) or an
// end-of-stream word (in_tuser high). Results leave on the out_ channel: a
// message byte, a message end with its length, overflow, or an end-of-stream
// status, coded in out_tuser. The end marker is held in a window of up to
// seven bytes; a byte is only emitted once it cannot start the marker, and the
// marker itself is dropped. The configuration channel writes the marker bytes,
// the marker length and the length limit; it is always ready.
// Each result is registered in the output register, or in the skid register
// while the receiver stalls. Throughput: one word per cycle while in_tready is
// high; the marker compare against the window is parallel, in a single cycle.
// Stall: an output register and a skid register hold up to two results, so a
// word is still taken in the cycle the receiver first stalls; in_tready drops
// while the skid register is full.
// Reset: rst_n, synchronous, clears the window, message state and both result
// registers and returns the configuration to marker 0x0a, length 1, limit 4096.
`timescale 1ns / 1ps
`include "end_marker_stream_deframer_assert.svh"
module end_marker_stream_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tuser,   // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // out_byte, message_length
  output logic [2:0]                     out_tuser,  // kind
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [emd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emd_pkg::MARKER_W-1:0]   cfg_data
);
  import emd_pkg::*;

  logic [MARKER_W-1:0]  marker_r, marker_nxt;
  logic [MLEN_W-1:0]    mlen_r, mlen_nxt;
  logic [LEN_W-1:0]     max_len_r, max_len_nxt;
  logic [7:0]           win_r [MAX_MARKER_BYTES];
  logic [7:0]           win_nxt [MAX_MARKER_BYTES];
  logic [7:0]           mk [MAX_MARKER_BYTES];
  logic [HELD_W-1:0]    held_r, held_nxt, held_eff;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 disc_r, disc_nxt;
  logic                 ended_r, ended_nxt;
  logic [HELD_W-1:0]    eff_len, need;
  logic                 in_fire, cfg_fire, match, push_valid;
  logic [7:0]           oldest;
  result_t              push_data, pop_data;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    if (mlen_r == '0) begin
      eff_len = HELD_W'(1);
    end else if (mlen_r > HELD_W'(MAX_MARKER_BYTES)) begin
      eff_len = HELD_W'(MAX_MARKER_BYTES);
    end else begin
      eff_len = mlen_r;
    end
    need     = eff_len - HELD_W'(1);
    held_eff = (held_r > need) ? need : held_r;
    for (int i = 0; i < MAX_MARKER_BYTES; i++) begin
      mk[i] = marker_r[8*i +: 8];
    end
    match = (in_tdata == mk[need[WIN_IDX_W-1:0]]);
    for (int i = 0; i < MAX_MARKER_BYTES - 1; i++) begin
      if (HELD_W'(i) < need && win_r[i] != mk[i]) begin
        match = 1'b0;
      end
    end
    oldest = (need == '0) ? in_tdata : win_r[0];
  end

  always_comb begin
    marker_nxt  = marker_r;
    mlen_nxt    = mlen_r;
    max_len_nxt = max_len_r;
    win_nxt     = win_r;
    held_nxt    = held_r;
    len_nxt     = len_r;
    disc_nxt    = disc_r;
    ended_nxt   = ended_r;
    push_valid  = 1'b0;
    push_data   = '0;

    if (in_fire) begin
      if (in_tuser) begin
        push_valid     = 1'b1;
        push_data.kind = (held_r != '0 || len_r != '0 || disc_r) ?
                         KIND_EOF_NO_MARKER : KIND_EOS;
        for (int i = 0; i < MAX_MARKER_BYTES; i++) win_nxt[i] = '0;
        held_nxt  = '0;
        len_nxt   = '0;
        disc_nxt  = 1'b0;
        ended_nxt = 1'b1;
      end else if (!ended_r) begin
        held_nxt = held_eff;
        if (held_eff < need) begin
          for (int i = 0; i < MAX_MARKER_BYTES; i++) begin
            if (HELD_W'(i) == held_eff) win_nxt[i] = in_tdata;
          end
          held_nxt = held_eff + HELD_W'(1);
        end else if (match) begin
          for (int i = 0; i < MAX_MARKER_BYTES; i++) win_nxt[i] = '0;
          held_nxt = '0;
          len_nxt  = '0;
          disc_nxt = 1'b0;
          if (!disc_r) begin
            push_valid        = 1'b1;
            push_data.kind    = KIND_END;
            push_data.msg_len = len_r;
          end
        end else begin
          for (int i = 0; i < MAX_MARKER_BYTES - 1; i++) begin
            if (HELD_W'(i + 1) < need) win_nxt[i] = win_r[i + 1];
          end
          for (int i = 0; i < MAX_MARKER_BYTES; i++) begin
            if (HELD_W'(i + 1) == need) win_nxt[i] = in_tdata;
          end
          if (!disc_r) begin
            push_valid = 1'b1;
            if (len_r >= max_len_r) begin
              disc_nxt       = 1'b1;
              push_data.kind = KIND_OVERFLOW;
            end else begin
              len_nxt            = len_r + LEN_W'(1);
              push_data.kind     = KIND_BYTE;
              push_data.out_byte = oldest;
            end
          end
        end
      end
    end

    if (cfg_fire) begin
      unique case (cfg_index)
        CFG_MARKER_BYTES: begin
          marker_nxt = cfg_data;
          for (int i = 0; i < MAX_MARKER_BYTES; i++) win_nxt[i] = '0;
          held_nxt = '0;
        end
        CFG_MARKER_LENGTH: begin
          mlen_nxt = cfg_data[MLEN_W-1:0];
          for (int i = 0; i < MAX_MARKER_BYTES; i++) win_nxt[i] = '0;
          held_nxt = '0;
        end
        CFG_MAX_LENGTH: begin
          max_len_nxt = cfg_data[LEN_W-1:0];
        end
        default: begin
          max_len_nxt = max_len_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r  <= MARKER_RESET;
      mlen_r    <= MLEN_RESET;
      max_len_r <= MAX_LEN_RESET;
      for (int i = 0; i < MAX_MARKER_BYTES; i++) win_r[i] <= '0;
      held_r    <= '0;
      len_r     <= '0;
      disc_r    <= 1'b0;
      ended_r   <= 1'b0;
    end else begin
      marker_r  <= marker_nxt;
      mlen_r    <= mlen_nxt;
      max_len_r <= max_len_nxt;
      win_r     <= win_nxt;
      held_r    <= held_nxt;
      len_r     <= len_nxt;
      disc_r    <= disc_nxt;
      ended_r   <= ended_nxt;
    end
  end

  emd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (in_tready),
    .pop_valid  (out_tvalid),
    .pop_data   (pop_data),
    .pop_ready  (out_tready)
  );

  assign out_tuser = pop_data.kind;
  assign out_tdata = {pop_data.msg_len, pop_data.out_byte};

  `EMD_ASSERT_NEXT(a_eos_clears, clk, rst_n, in_fire && in_tuser && !cfg_fire,
                   ended_r && !disc_r && held_r == '0 && len_r == '0)
  `EMD_ASSERT_IMPLY(a_stall_needs_output, clk, rst_n, !in_tready, out_tvalid)
  `EMD_ASSERT_NEXT(a_ended_data_idle, clk, rst_n,
                   in_fire && !in_tuser && ended_r && !cfg_fire,
                   $stable(len_r) && $stable(held_r) && $stable(disc_r))
  `EMD_ASSERT_IMPLY(a_held_in_window, clk, rst_n, 1'b1,
                    held_r < HELD_W'(MAX_MARKER_BYTES))

endmodule
